// ===== hdl/i2cled_pkg.sv =====
package i2cled_pkg;

    // Register map of the LED driver.
    localparam int REG_COUNT      = 32;
    localparam int LED_COUNT      = 16;
    localparam int LEDS_PER_MODE  = 4;
    localparam int MODE_REG_COUNT = LED_COUNT / LEDS_PER_MODE;
    localparam int LED_IDX_W      = $clog2(LED_COUNT);
    localparam int MODE_IDX_W     = $clog2(MODE_REG_COUNT);
    localparam int PTR_W          = 5;

    localparam logic [PTR_W-1:0] PWM_BASE  = 5'h02;
    localparam logic [PTR_W-1:0] MODE_BASE = 5'h14;
    localparam logic [PTR_W-1:0] PTR_LAST  = 5'h1B;
    localparam logic [7:0]       PTR_MASK      = 8'h1F;
    localparam logic [7:0]       AUTO_INC_MASK = 8'hE0;
    localparam logic [7:0]       MODE_MASK     = 8'h03;

    // Bus event carried in s_tuser.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_START_BUSY = 3'd1,
        ERR_READ_ADDR  = 3'd2,
        ERR_DATA_READ  = 3'd3,
        ERR_GROUP_MODE = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_FULL  = 2'd1,
        MODE_PWM   = 2'd2,
        MODE_GROUP = 2'd3
    } led_mode_t;

endpackage

// ===== hdl/i2c_led_driver_register_slave.sv =====
// Register slave of a 16-channel LED driver, fed with bus events (start, stop,
// write byte, read byte) one transaction at a time on the s_ stream, and
// answering every event with exactly one result transaction on the m_ stream.
// A start with the write bit opens the pointer phase; the first data byte
// loads the 5-bit register pointer and turns auto-increment on when any of
// its top three bits is set; later bytes are stored in the selected register,
// with the pointer advancing and wrapping to zero past 0x1B under
// auto-increment. A stop clears the pointer and auto-increment and returns to
// idle. Each result carries the acknowledge bit, an error code, and the mode
// and output value of the LED picked by led_index, as seen after the event.
// The block takes one transaction per clock cycle while the result stream is
// not stalled. An accepted event sits in the input register while the state
// update and LED lookup are worked out, and its result is then loaded into the
// result register, which drives m_tvalid and holds the result transaction
// until m_tready takes it. A stalled result holds the event behind it in the
// input register, and s_tready stays low only while both registers are full.
// Only the PWM registers (0x02..0x11) and the LED mode registers (0x14..0x17)
// are ever read back, so only those are kept in flip-flops; writes to any
// other register are acknowledged and dropped.
module i2c_led_driver_register_slave
    import i2cled_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rw_bit [0], data_byte [8:1], led_index [12:9]
    input  logic [1:0]  s_tuser,   // op [1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ack [0], error [3:1], led_mode [5:4], led_value [13:6]
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_POINTER = 2'd1,
        PH_WRITE   = 2'd2
    } phase_t;

    // Input register.
    logic                 in_valid_reg;
    op_t                  in_op_reg;
    logic                 in_rw_reg;
    logic [7:0]           in_data_reg;
    logic [LED_IDX_W-1:0] in_idx_reg;

    // Result register.
    logic       out_valid_reg;
    logic       out_ack_reg;
    err_t       out_err_reg;
    led_mode_t  out_mode_reg;
    logic [7:0] out_value_reg;

    // Bus state and the readable part of the register file.
    phase_t           phase_reg, phase_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             auto_inc_reg, auto_inc_next;
    logic [7:0]       pwm_reg  [LED_COUNT];
    logic [7:0]       mode_reg [MODE_REG_COUNT];

    logic                  step;
    logic                  reg_wr;
    logic [PTR_W-1:0]      pwm_off;
    logic [PTR_W-1:0]      mode_off;
    logic                  pwm_wr;
    logic                  mode_wr;
    logic [PTR_W:0]        ptr_inc;
    logic                  ack_next;
    err_t                  ev_err;
    err_t                  err_next;
    logic [MODE_IDX_W-1:0] sel_mode_idx;
    logic [7:0]            sel_mode_byte;
    logic [7:0]            sel_pwm_byte;
    led_mode_t             mode_next;
    logic [7:0]            value_next;

    // The held event moves on whenever the result register is free or drains.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_mode_reg, out_err_reg, out_ack_reg};

    // Register write decode for a data byte in the write phase.
    assign reg_wr   = step && (in_op_reg == OP_WRITE) && (phase_reg == PH_WRITE)
                      && ({1'b0, ptr_reg} < (PTR_W+1)'(REG_COUNT));
    assign pwm_off  = ptr_reg - PWM_BASE;
    assign mode_off = ptr_reg - MODE_BASE;
    assign pwm_wr   = reg_wr && (ptr_reg >= PWM_BASE)
                      && ({1'b0, pwm_off} < (PTR_W+1)'(LED_COUNT));
    assign mode_wr  = reg_wr && (ptr_reg >= MODE_BASE)
                      && ({1'b0, mode_off} < (PTR_W+1)'(MODE_REG_COUNT));
    assign ptr_inc  = {1'b0, ptr_reg} + (PTR_W+1)'(1);

    always_comb begin
        phase_next    = phase_reg;
        ptr_next      = ptr_reg;
        auto_inc_next = auto_inc_reg;
        ack_next      = 1'b0;
        ev_err        = ERR_NONE;
        case (in_op_reg)
            OP_START: begin
                ack_next = 1'b1;
                if (phase_reg == PH_POINTER || phase_reg == PH_WRITE) begin
                    ev_err = ERR_START_BUSY;
                end else if (in_rw_reg) begin
                    ev_err = ERR_READ_ADDR;
                end else begin
                    phase_next = PH_POINTER;
                end
            end
            OP_STOP: begin
                ptr_next      = '0;
                auto_inc_next = 1'b0;
                phase_next    = PH_IDLE;
            end
            OP_WRITE: begin
                ack_next = 1'b1;
                if (phase_reg == PH_POINTER) begin
                    auto_inc_next = |(in_data_reg & AUTO_INC_MASK);
                    ptr_next      = PTR_W'(in_data_reg & PTR_MASK);
                    phase_next    = PH_WRITE;
                end else if (phase_reg == PH_WRITE && auto_inc_reg) begin
                    if (ptr_inc > {1'b0, PTR_LAST}) begin
                        ptr_next = '0;
                    end else begin
                        ptr_next = ptr_inc[PTR_W-1:0];
                    end
                end
            end
            default: begin
                ev_err = ERR_DATA_READ;
            end
        endcase
    end

    // LED lookup on the register file as it stands after this event, so a
    // byte written by this very event is forwarded into the read.
    assign sel_mode_idx = in_idx_reg[LED_IDX_W-1:LED_IDX_W-MODE_IDX_W];

    always_comb begin
        if (mode_wr && (mode_off[MODE_IDX_W-1:0] == sel_mode_idx)) begin
            sel_mode_byte = in_data_reg;
        end else begin
            sel_mode_byte = mode_reg[sel_mode_idx];
        end
        if (pwm_wr && (pwm_off[LED_IDX_W-1:0] == in_idx_reg)) begin
            sel_pwm_byte = in_data_reg;
        end else begin
            sel_pwm_byte = pwm_reg[in_idx_reg];
        end
    end

    always_comb begin
        mode_next  = led_mode_t'(2'((sel_mode_byte >> {in_idx_reg[1:0], 1'b0}) & MODE_MASK));
        err_next   = ev_err;
        value_next = '0;
        case (mode_next)
            MODE_OFF: begin
                value_next = '0;
            end
            MODE_FULL: begin
                value_next = 8'd1;
            end
            MODE_PWM: begin
                value_next = sel_pwm_byte;
            end
            default: begin
                // Group dimming is not supported; report it unless the event
                // itself already failed.
                if (ev_err == ERR_NONE) begin
                    err_next = ERR_GROUP_MODE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            ptr_reg       <= '0;
            auto_inc_reg  <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++) begin
                pwm_reg[i] <= '0;
            end
            for (int i = 0; i < MODE_REG_COUNT; i++) begin
                mode_reg[i] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_op_reg    <= op_t'(s_tuser[1:0]);
                in_rw_reg    <= s_tdata[0];
                in_data_reg  <= s_tdata[8:1];
                in_idx_reg   <= s_tdata[9 +: LED_IDX_W];
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end

            if (step) begin
                out_valid_reg <= 1'b1;
                out_ack_reg   <= ack_next;
                out_err_reg   <= err_next;
                out_mode_reg  <= mode_next;
                out_value_reg <= value_next;
                phase_reg     <= phase_next;
                ptr_reg       <= ptr_next;
                auto_inc_reg  <= auto_inc_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (pwm_wr) begin
                pwm_reg[pwm_off[LED_IDX_W-1:0]] <= in_data_reg;
            end
            if (mode_wr) begin
                mode_reg[mode_off[MODE_IDX_W-1:0]] <= in_data_reg;
            end
        end
    end

endmodule
